/* src/safs_pkg.sv */
`timescale 1ns / 1ps

package safs_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
    } t_rsp;

endpackage

/* src/slot_allocator_free_stack_core.sv */
`timescale 1ns / 1ps

// channel    | valid    | ready    | payload             | direction
// -----------+----------+----------+---------------------+----------
// request    | i_valid  | o_ready  | i_req  (t_req)      | in
// response   | o_valid  | i_ready  | o_rsp  (t_rsp)      | out
//
// one transaction per cycle sustained while i_ready holds; a response shows on o_valid once
// its request has passed the request register, then the response register
// in-use map and free stack: one write, one registered read, launched before execution
// reset (i_rst_n low, synchronous) empties the pool at once with no clearing pass;
// map entries at or above the high-water mark are never trusted
// a stalled response holds the request register; otherwise requests keep flowing

module slot_allocator_free_stack_core
    import safs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    // memories
    logic              map_mem   [SLOT_COUNT];
    logic [SLOT_W-1:0] stack_mem [SLOT_COUNT];

    // request stage
    logic r_req_valid;
    t_req r_req;
    logic r_map_rd;      // in-use bit of r_req.slot, forwarded

    // allocator state
    logic [COUNT_W-1:0] r_depth,  n_depth;
    logic [COUNT_W-1:0] r_hw,     n_hw;
    logic [SLOT_W-1:0]  r_top;    // free_stack[r_depth-1], forwarded

    // response stage
    logic r_out_valid;
    t_rsp r_out, n_out;

    // execute controls
    logic              exec;
    logic              map_we;
    logic [SLOT_W-1:0] map_waddr;
    logic              map_wdata;
    logic              push;
    logic              live;
    logic [SLOT_W-1:0] top_raddr;
    logic [COUNT_W-1:0] top_idx;

    assign exec    = r_req_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_req_valid || exec;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // a slot counts as live only below the high-water mark, which keeps
    // never-written map entries out of the picture
    assign live = r_map_rd && ({1'b0, r_req.slot} < r_hw);

    // execute one request
    always_comb begin
        n_depth            = r_depth;
        n_hw               = r_hw;
        map_we             = 1'b0;
        map_waddr          = r_req.slot;
        map_wdata          = 1'b0;
        push               = 1'b0;
        n_out.slot_out     = r_req.slot;
        n_out.status       = STATUS_OK;
        if (exec) begin
            case (r_req.func)
                FUNC_ALLOC: begin
                    if (r_depth != '0) begin
                        // reuse most recently freed slot
                        n_out.slot_out = r_top;
                        map_we         = 1'b1;
                        map_waddr      = r_top;
                        map_wdata      = 1'b1;
                        n_depth        = r_depth - COUNT_W'(1);
                    end else if (r_hw < COUNT_W'(SLOT_COUNT)) begin
                        // fresh slot at the high-water mark
                        n_out.slot_out = r_hw[SLOT_W-1:0];
                        map_we         = 1'b1;
                        map_waddr      = r_hw[SLOT_W-1:0];
                        map_wdata      = 1'b1;
                        n_hw           = r_hw + COUNT_W'(1);
                    end else begin
                        n_out.slot_out = '0;
                        n_out.status   = STATUS_FULL;
                    end
                end
                FUNC_FREE: begin
                    if (live && (r_depth < COUNT_W'(SLOT_COUNT))) begin
                        map_we    = 1'b1;
                        map_wdata = 1'b0;
                        push      = 1'b1;
                        n_depth   = r_depth + COUNT_W'(1);
                    end else begin
                        n_out.status = STATUS_NOT_LIVE;
                    end
                end
                FUNC_QUERY: begin
                    if (!live) begin
                        n_out.status = STATUS_NOT_LIVE;
                    end
                end
                default: begin
                    // unused code: echo, no state change
                end
            endcase
        end
        n_out.live_count = n_hw - n_depth;
    end

    // top of stack after this cycle sits at n_depth-1
    assign top_idx   = n_depth - COUNT_W'(1);
    assign top_raddr = top_idx[SLOT_W-1:0];

    // in-use map: write from execute, read for the incoming request
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (i_valid && o_ready) begin
            if (map_we && (map_waddr == i_req.slot)) begin
                r_map_rd <= map_wdata;
            end else begin
                r_map_rd <= map_mem[i_req.slot];
            end
        end
    end

    // free stack: push writes at r_depth, top is prefetched every cycle or taken from the push
    always_ff @(posedge i_clk) begin
        if (push) begin
            stack_mem[r_depth[SLOT_W-1:0]] <= r_req.slot;
            r_top                          <= r_req.slot;
        end else begin
            r_top <= stack_mem[top_raddr];
        end
    end

    // request and response registers, allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_hw        <= '0;
        end else begin
            if (o_ready) begin
                r_req_valid <= i_valid;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_depth <= n_depth;
            r_hw    <= n_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
        if (exec) begin
            r_out <= n_out;
        end
    end

    // checks
    a_depth_le_hw : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_hw)
        else $error("free stack deeper than high-water mark");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.live_count <= COUNT_W'(SLOT_COUNT)))
        else $error("live count above pool size");

    a_full_means_all_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == STATUS_FULL)) |->
            (o_rsp.live_count == COUNT_W'(SLOT_COUNT)))
        else $error("pool full reported with slots still free");

    a_alloc_ok_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (r_req.func == FUNC_ALLOC) && (n_out.status == STATUS_OK)) |=>
            ((r_hw - r_depth) == ($past(r_hw) - $past(r_depth) + COUNT_W'(1))))
        else $error("allocation did not raise live count by one");

endmodule
